### hdl/kmer_pair_compare_top_assert.svh
// Assertion macros shared by the checker of the k-mer pair compare block
`ifndef KMER_PAIR_COMPARE_TOP_ASSERT_SVH
`define KMER_PAIR_COMPARE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define KPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kpc assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define KPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kpc assertion failed");

`endif

### hdl/kpc_pkg.sv
// Package: constants and types of the k-mer pair compare block
package kpc_pkg;

  localparam int unsigned MaxLen    = 256;
  localparam int unsigned PlaneBits = 64;
  localparam int unsigned QProdMax  = 65025;
  localparam int unsigned QSumCap   = 16777215;
  localparam int unsigned QSumMaxInt =
    (MaxLen * QProdMax > QSumCap) ? QSumCap : MaxLen * QProdMax;

  localparam int unsigned CountW  = 7;
  localparam int unsigned QualW   = 25;
  localparam logic [CountW-1:0] CountSat = CountW'(PlaneBits + 1);

  // clamp bounds, one bit wider than the stored sum
  localparam logic signed [QualW:0] QSumMax = (QualW + 1)'(QSumMaxInt);
  localparam logic signed [QualW:0] QSumMin = -QSumMax;

  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChC = 8'h43;

  // finished pair, handed from the accumulator to the result stage
  typedef struct packed {
    logic [PlaneBits-1:0]     gc_x;
    logic [PlaneBits-1:0]     dir_x;
    logic                     long_pair;
    logic                     chars_differ;
    logic                     length_mismatch;
    logic signed [QualW-1:0]  quality_sum;
  } snap_t;

endpackage

### hdl/kpc_if.sv
// Interfaces: input word channel and result word channel
interface kpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_a;
  logic [7:0] base_b;
  logic [7:0] qual_a;
  logic [7:0] qual_b;
  logic       has_a;
  logic       has_b;
  logic       last;

  modport source (output valid, base_a, base_b, qual_a, qual_b, has_a, has_b, last,
                  input ready);
  modport sink   (input valid, base_a, base_b, qual_a, qual_b, has_a, has_b, last,
                  output ready);
endinterface

interface kpc_out_if;
  logic               valid;
  logic               ready;
  logic               equal;
  logic [6:0]         mismatch_count;
  logic signed [24:0] match_quality;
  logic               length_differs;

  modport source (output valid, equal, mismatch_count, match_quality, length_differs,
                  input ready);
  modport sink   (input valid, equal, mismatch_count, match_quality, length_differs,
                  output ready);
endinterface

### hdl/kmer_pair_compare_top.sv
// Top level of the k-mer pair compare block
//
// Input channel in_i: one word per position of the pair, carrying the base and
// quality of each k-mer, presence flags and a last flag. Output channel out_o:
// one word per pair, sent for the word marked last, with the equality flag,
// mismatch count over the first 64 positions, signed quality score and the
// length-differs flag. Both channels use valid/ready.
//
// Throughput: one input word per cycle while in_i.ready is high. Three register
// stages (input register, accumulator with pair snapshot, result register); the
// last word of a pair moves into the snapshot, its result word then into out_o.
//
// Reset clears the accumulator and all valid flags; no words are held.
// When the receiver stalls, the result register holds its word, a second
// finished pair waits in the snapshot register, and words that are not last
// keep flowing into the accumulator. Only a last word that finds both of
// those full waits in the input register, which then lowers in_i.ready.
module kmer_pair_compare_top
  import kpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  kpc_in_if.sink    in_i,
  kpc_out_if.source out_o
);

  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  kpc_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  kpc_result u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .out_o        (out_o)
  );

endmodule

### hdl/kpc_accum.sv
// Input register, per-pair accumulator and finished-pair snapshot register
module kpc_accum
  import kpc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  kpc_in_if.sink in_i,
  output logic   snap_valid_o,
  input  logic   snap_ready_i,
  output snap_t  snap_o
);

  // input register
  logic       v0_q, v0_d;
  logic [7:0] ba_q, bb_q, qa_q, qb_q;
  logic       ha_q, hb_q, last_q;

  // accumulator
  logic [PlaneBits-1:0]    gca_q, gca_d, dira_q, dira_d, gcb_q, gcb_d, dirb_q, dirb_d;
  logic [CountW-1:0]       cnt_q, cnt_d;
  logic signed [QualW-1:0] sum_q, sum_d;
  logic                    cd_q, cd_d, lm_q, lm_d;

  // snapshot
  logic  snap_valid_q, snap_valid_d;
  snap_t snap_q, snap_d;

  // updated accumulator values for the word in the input register
  logic [PlaneBits-1:0]    gca_n, dira_n, gcb_n, dirb_n;
  logic [CountW-1:0]       cnt_n;
  logic signed [QualW-1:0] sum_n;
  logic                    cd_n, lm_n;
  logic [15:0]             prod;
  logic signed [QualW:0]   sum_w;
  logic                    both, in_planes;

  logic s1_free, consume, accept;

  assign s1_free  = !snap_valid_q || snap_ready_i;
  assign consume  = v0_q && (!last_q || s1_free);
  assign in_i.ready = !v0_q || consume;
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    both      = ha_q && hb_q;
    in_planes = !cnt_q[CountW-1];
    prod      = 16'(qa_q) * 16'(qb_q);

    gca_n  = gca_q;
    dira_n = dira_q;
    gcb_n  = gcb_q;
    dirb_n = dirb_q;
    if (in_planes && ha_q) begin
      gca_n  = {gca_q[PlaneBits-2:0], (ba_q == ChG) || (ba_q == ChC)};
      dira_n = {dira_q[PlaneBits-2:0], (ba_q == ChA) || (ba_q == ChG)};
    end
    if (in_planes && hb_q) begin
      gcb_n  = {gcb_q[PlaneBits-2:0], (bb_q == ChG) || (bb_q == ChC)};
      dirb_n = {dirb_q[PlaneBits-2:0], (bb_q == ChA) || (bb_q == ChG)};
    end

    lm_n = lm_q || (ha_q != hb_q);
    cd_n = cd_q || (both && (ba_q != bb_q));

    sum_w = (ba_q == bb_q) ? (QualW + 1)'(sum_q) + $signed((QualW + 1)'(prod))
                           : (QualW + 1)'(sum_q) - $signed((QualW + 1)'(prod));
    if (!both) begin
      sum_n = sum_q;
    end else if (sum_w > QSumMax) begin
      sum_n = QualW'(QSumMax);
    end else if (sum_w < QSumMin) begin
      sum_n = QualW'(QSumMin);
    end else begin
      sum_n = QualW'(sum_w);
    end

    cnt_n = (cnt_q < CountSat) ? cnt_q + CountW'(1) : cnt_q;
  end

  always_comb begin
    v0_d = v0_q;
    if (accept) begin
      v0_d = 1'b1;
    end else if (consume) begin
      v0_d = 1'b0;
    end

    gca_d  = gca_q;
    dira_d = dira_q;
    gcb_d  = gcb_q;
    dirb_d = dirb_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    cd_d   = cd_q;
    lm_d   = lm_q;

    snap_valid_d = snap_valid_q && !snap_ready_i;
    snap_d       = snap_q;

    snap_d.gc_x            = gca_n ^ gcb_n;
    snap_d.dir_x           = dira_n ^ dirb_n;
    snap_d.long_pair       = (cnt_n == CountSat);
    snap_d.chars_differ    = cd_n;
    snap_d.length_mismatch = lm_n;
    snap_d.quality_sum     = sum_n;
    if (!(consume && last_q)) begin
      snap_d = snap_q;
    end

    if (consume) begin
      if (last_q) begin
        // pair done: hand it on and start clean
        snap_valid_d = 1'b1;
        gca_d  = '0;
        dira_d = '0;
        gcb_d  = '0;
        dirb_d = '0;
        cnt_d  = '0;
        sum_d  = '0;
        cd_d   = 1'b0;
        lm_d   = 1'b0;
      end else begin
        gca_d  = gca_n;
        dira_d = dira_n;
        gcb_d  = gcb_n;
        dirb_d = dirb_n;
        cnt_d  = cnt_n;
        sum_d  = sum_n;
        cd_d   = cd_n;
        lm_d   = lm_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q         <= 1'b0;
      gca_q        <= '0;
      dira_q       <= '0;
      gcb_q        <= '0;
      dirb_q       <= '0;
      cnt_q        <= '0;
      sum_q        <= '0;
      cd_q         <= 1'b0;
      lm_q         <= 1'b0;
      snap_valid_q <= 1'b0;
    end else begin
      v0_q         <= v0_d;
      gca_q        <= gca_d;
      dira_q       <= dira_d;
      gcb_q        <= gcb_d;
      dirb_q       <= dirb_d;
      cnt_q        <= cnt_d;
      sum_q        <= sum_d;
      cd_q         <= cd_d;
      lm_q         <= lm_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ba_q   <= in_i.base_a;
      bb_q   <= in_i.base_b;
      qa_q   <= in_i.qual_a;
      qb_q   <= in_i.qual_b;
      ha_q   <= in_i.has_a;
      hb_q   <= in_i.has_b;
      last_q <= in_i.last;
    end
    snap_q <= snap_d;
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

### hdl/kpc_result.sv
// Result stage: mismatch popcount, equality decision and output register
module kpc_result
  import kpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       snap_valid_i,
  output logic       snap_ready_o,
  input  snap_t      snap_i,
  kpc_out_if.source  out_o
);

  logic                    valid_q, valid_d;
  logic                    equal_q, equal_d;
  logic [CountW-1:0]       mcount_q, mcount_d;
  logic signed [QualW-1:0] qual_q, qual_d;
  logic                    ldiff_q, ldiff_d;
  logic                    free, load;
  logic [PlaneBits-1:0]    diff;

  // two-level count: eight bytes, then the eight byte counts
  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  always_comb begin
    logic [3:0] grp [8];
    diff = snap_i.gc_x | snap_i.dir_x;
    for (int g = 0; g < 8; g++) begin
      grp[g] = ones8(diff[g*8 +: 8]);
    end
    mcount_d = '0;
    for (int g = 0; g < 8; g++) begin
      mcount_d = mcount_d + CountW'(grp[g]);
    end
  end

  assign free         = !valid_q || out_o.ready;
  assign load         = snap_valid_i && free;
  assign snap_ready_o = free;

  always_comb begin
    valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);
    equal_d = !snap_i.length_mismatch && (snap_i.gc_x == '0) && (snap_i.dir_x == '0) &&
              (!snap_i.long_pair || !snap_i.chars_differ);
    qual_d  = snap_i.length_mismatch ? '0 : snap_i.quality_sum;
    ldiff_d = snap_i.length_mismatch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      equal_q  <= equal_d;
      mcount_q <= mcount_d;
      qual_q   <= qual_d;
      ldiff_q  <= ldiff_d;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.equal          = equal_q;
  assign out_o.mismatch_count = mcount_q;
  assign out_o.match_quality  = qual_q;
  assign out_o.length_differs = ldiff_q;

endmodule

### hdl/kpc_chk.sv
// Port checker of the k-mer pair compare block and its bind
`include "kmer_pair_compare_top_assert.svh"

module kpc_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              equal_i,
  input logic [6:0]        mismatch_count_i,
  input logic signed [24:0] match_quality_i,
  input logic              length_differs_i
);

  // a stalled result word stays put
  `KPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(equal_i) && $stable(mismatch_count_i) && $stable(match_quality_i) && $stable(length_differs_i))

  `KPC_ASSERT_NOW(a_count_range, clk_i, rst_ni, out_valid_i, mismatch_count_i <= 7'd64)

  `KPC_ASSERT_NOW(a_len_zero_q, clk_i, rst_ni, out_valid_i && length_differs_i,
    match_quality_i == 25'sd0 && !equal_i)

  `KPC_ASSERT_NOW(a_equal_clean, clk_i, rst_ni, out_valid_i && equal_i,
    mismatch_count_i == 7'd0 && !length_differs_i)

endmodule

bind kmer_pair_compare_top kpc_chk u_kpc_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .equal_i          (out_o.equal),
  .mismatch_count_i (out_o.mismatch_count),
  .match_quality_i  (out_o.match_quality),
  .length_differs_i (out_o.length_differs)
);

### bench/tb.sv
// Testbench of the k-mer pair compare block: directed and random pairs checked by a predictor
`timescale 1ns / 1ps
module tb;
  import kpc_pkg::*;

  localparam logic [7:0]  ChT         = 8'h54;
  localparam logic [7:0]  ChN         = 8'h4E;
  localparam logic [7:0]  ChLowA      = 8'h61;
  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned StallPct    = 32;
  localparam int unsigned MaxShown    = 10;

  typedef struct packed {
    logic [7:0] base_a;
    logic [7:0] base_b;
    logic [7:0] qual_a;
    logic [7:0] qual_b;
    logic       has_a;
    logic       has_b;
    logic       last;
  } kmer_word_t;

  typedef struct packed {
    logic               equal;
    logic [6:0]         mismatch_count;
    logic signed [24:0] match_quality;
    logic               length_differs;
  } pair_verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  kpc_in_if  word_ch ();
  kpc_out_if verdict_ch ();

  kmer_pair_compare_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_ch),
    .out_o  (verdict_ch)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // predictor state of the pair being accumulated
  logic [PlaneBits-1:0] gc_a_q, dir_a_q, gc_b_q, dir_b_q;
  int unsigned          position_n;
  longint               quality_acc;
  bit                   chars_seen_differ;
  bit                   lengths_split;

  pair_verdict_t verdicts_due[$];
  int unsigned   cycle_count = 0;
  int unsigned   error_count = 0;
  int unsigned   words_sent  = 0;
  bit            stall_enable = 1'b1;

  function automatic void clear_pair_state();
    gc_a_q            = '0;
    dir_a_q           = '0;
    gc_b_q            = '0;
    dir_b_q           = '0;
    position_n        = 0;
    quality_acc       = 0;
    chars_seen_differ = 1'b0;
    lengths_split     = 1'b0;
  endfunction

  // {gc, dir}; anything that is not A, C or G packs like T
  function automatic logic [1:0] base_planes(input logic [7:0] ch);
    return {(ch == ChG) || (ch == ChC), (ch == ChA) || (ch == ChG)};
  endfunction

  function automatic void accumulate_position(input kmer_word_t w);
    logic [1:0]    pa;
    logic [1:0]    pb;
    longint        prod;
    pair_verdict_t v;
    pa   = base_planes(w.base_a);
    pb   = base_planes(w.base_b);
    prod = longint'(w.qual_a) * longint'(w.qual_b);
    if (w.has_a != w.has_b) lengths_split = 1'b1;
    if (position_n < PlaneBits) begin
      if (w.has_a) begin
        gc_a_q  = {gc_a_q[PlaneBits-2:0], pa[1]};
        dir_a_q = {dir_a_q[PlaneBits-2:0], pa[0]};
      end
      if (w.has_b) begin
        gc_b_q  = {gc_b_q[PlaneBits-2:0], pb[1]};
        dir_b_q = {dir_b_q[PlaneBits-2:0], pb[0]};
      end
    end
    if (w.has_a && w.has_b) begin
      if (w.base_a == w.base_b) begin
        quality_acc += prod;
      end else begin
        quality_acc -= prod;
        chars_seen_differ = 1'b1;
      end
      if (quality_acc > longint'(QSumMaxInt)) quality_acc = longint'(QSumMaxInt);
      if (quality_acc < -longint'(QSumMaxInt)) quality_acc = -longint'(QSumMaxInt);
    end
    if (position_n < CountSat) position_n++;
    if (w.last) begin
      v.equal = !lengths_split && (gc_a_q == gc_b_q) && (dir_a_q == dir_b_q) &&
                ((position_n <= PlaneBits) || !chars_seen_differ);
      v.mismatch_count = 7'($countones((gc_a_q ^ gc_b_q) | (dir_a_q ^ dir_b_q)));
      v.match_quality  = lengths_split ? 25'sd0 : 25'(quality_acc);
      v.length_differs = lengths_split;
      verdicts_due.push_back(v);
      clear_pair_state();
    end
  endfunction

  function automatic kmer_word_t position_word(input logic [7:0] ba, input logic [7:0] bb,
                                               input logic [7:0] qa, input logic [7:0] qb,
                                               input logic ha = 1'b1, input logic hb = 1'b1);
    kmer_word_t w;
    w = '{base_a: ba, base_b: bb, qual_a: qa, qual_b: qb, has_a: ha, has_b: hb, last: 1'b0};
    return w;
  endfunction

  function automatic string repeat_text(input string unit, input int unsigned n);
    string s;
    s = "";
    repeat (n) s = {s, unit};
    return s;
  endfunction

  function automatic logic [7:0] random_base();
    logic [7:0] ch;
    if ($urandom_range(99) >= 88) return 8'($urandom);
    case ($urandom_range(3))
      0: ch = ChA;
      1: ch = ChC;
      2: ch = ChG;
      default: ch = ChT;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] random_qual();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return 8'h00;
    if (pick < 16) return 8'hFF;
    return 8'($urandom);
  endfunction

  // one word; valid stays high across back-to-back words
  task automatic send_word(input kmer_word_t w);
    while (stall_enable && ($urandom_range(99) < StallPct)) begin
      word_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    word_ch.valid = 1'b1;
    {word_ch.base_a, word_ch.base_b, word_ch.qual_a, word_ch.qual_b,
     word_ch.has_a, word_ch.has_b, word_ch.last} = w;
    do @(posedge clk_i); while (!word_ch.ready);
    accumulate_position(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_pair(input kmer_word_t pair[$]);
    kmer_word_t w;
    foreach (pair[i]) begin
      w      = pair[i];
      w.last = (i == pair.size() - 1);
      send_word(w);
    end
  endtask

  // the shorter text leaves its k-mer's flag low at the tail
  task automatic send_text_pair(input string seq_a, input string seq_b,
                                input logic [7:0] q_a, input logic [7:0] q_b);
    kmer_word_t  pair[$];
    int unsigned n;
    logic        ha, hb;
    n = (seq_a.len() > seq_b.len()) ? seq_a.len() : seq_b.len();
    for (int unsigned i = 0; i < n; i++) begin
      ha = i < seq_a.len();
      hb = i < seq_b.len();
      pair.push_back(position_word(ha ? seq_a[i] : 8'h00, hb ? seq_b[i] : 8'h00,
                                   q_a, q_b, ha, hb));
    end
    send_pair(pair);
  endtask

  task automatic send_random_pair();
    kmer_word_t  pair[$];
    kmer_word_t  w;
    int unsigned n, pick;
    bit          mirrored, broken;
    pick = $urandom_range(99);
    if (pick < 70)      n = $urandom_range(12, 1);
    else if (pick < 92) n = $urandom_range(63, 13);
    else                n = $urandom_range(96, 64);
    broken   = $urandom_range(99) < 15;
    mirrored = $urandom_range(1);
    for (int unsigned i = 0; i < n; i++) begin
      w = position_word(random_base(), 8'h00, random_qual(), random_qual());
      w.base_b = mirrored ? w.base_a : random_base();
      if (broken) begin
        w.has_a = $urandom_range(99) < 80;
        w.has_b = $urandom_range(99) < 80;
      end
      pair.push_back(w);
    end
    if (mirrored && $urandom_range(1)) pair[$urandom_range(n - 1)].base_b = random_base();
    send_pair(pair);
  endtask

  task automatic test_single_positions();
    kmer_word_t pair[$];
    send_text_pair("A", "A", 8'hFF, 8'hFF);
    send_text_pair("G", "C", 8'h00, 8'hFF);
    // neither k-mer present, still one position
    pair.push_back(position_word(8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0));
    send_pair(pair);
  endtask

  task automatic test_character_codes();
    kmer_word_t pair[$];
    send_text_pair("ACGT", "ACGT", 8'h01, 8'h80);
    send_text_pair("GA", "AG", 8'h7F, 8'h02);
    // odd codes pack like T but still count as different characters
    pair.push_back(position_word(ChN, ChT, 8'hFF, 8'h01));
    pair.push_back(position_word(8'h00, ChT, 8'h55, 8'hAA));
    pair.push_back(position_word(8'hFF, ChT, 8'h0F, 8'hF0));
    pair.push_back(position_word(ChLowA, ChA, 8'h33, 8'hCC));
    send_pair(pair);
  endtask

  task automatic test_length_flags();
    kmer_word_t pair[$];
    send_text_pair("ACG", "AC", 8'h10, 8'h10);
    send_text_pair("T", "TA", 8'h20, 8'h30);
    // gap in A only
    pair.push_back(position_word(ChA, ChA, 8'h05, 8'h06));
    pair.push_back(position_word(ChC, ChC, 8'h07, 8'h08, 1'b0, 1'b1));
    pair.push_back(position_word(ChG, ChG, 8'h09, 8'h0A));
    send_pair(pair);
    pair.delete();
    // gap in both keeps the lengths equal
    pair.push_back(position_word(ChA, ChA, 8'h11, 8'h12));
    pair.push_back(position_word(ChG, ChC, 8'hFF, 8'hFF, 1'b0, 1'b0));
    pair.push_back(position_word(ChT, ChT, 8'h13, 8'h14));
    send_pair(pair);
  endtask

  task automatic test_plane_limits();
    send_text_pair(repeat_text("A", 64), repeat_text("T", 64), 8'hFF, 8'hFF);
    send_text_pair({repeat_text("T", 63), "N"}, repeat_text("T", 64), 8'h40, 8'h40);
    send_text_pair({repeat_text("ACGT", 16), "G"}, {repeat_text("ACGT", 16), "C"},
                   8'h10, 8'h20);
    send_text_pair({repeat_text("C", 65), "N"}, {repeat_text("C", 65), "X"}, 8'h21, 8'h43);
    send_text_pair(repeat_text("GATC", 18), repeat_text("GATC", 18), 8'hC8, 8'h64);
    send_text_pair(repeat_text("A", 70), repeat_text("A", 66), 8'hFF, 8'hFF);
  endtask

  task automatic test_quality_saturation();
    send_text_pair(repeat_text("G", 260), repeat_text("G", 260), 8'hFF, 8'hFF);
    send_text_pair(repeat_text("A", 260), repeat_text("C", 260), 8'hFF, 8'hFF);
    // clamps high, then backs off from the bound
    send_text_pair({repeat_text("A", 260), repeat_text("C", 10)}, repeat_text("A", 270),
                   8'hFF, 8'hFF);
  endtask

  task automatic test_random_pairs(input int unsigned n_words);
    int unsigned stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) send_random_pair();
  endtask

  task automatic test_steady_stream(input int unsigned n_words);
    stall_enable = 1'b0;
    test_random_pairs(n_words);
    stall_enable = 1'b1;
  endtask

  initial begin
    word_ch.valid = 1'b0;
    {word_ch.base_a, word_ch.base_b, word_ch.qual_a, word_ch.qual_b,
     word_ch.has_a, word_ch.has_b, word_ch.last} = '0;
    clear_pair_state();
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_single_positions();
    test_character_codes();
    test_length_flags();
    test_plane_limits();
    test_quality_saturation();
    test_random_pairs(100);
    test_steady_stream(100);
    word_ch.valid = 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // result side
  initial begin
    verdict_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      verdict_ch.ready = !stall_enable || ($urandom_range(99) >= StallPct);
    end
  end

  always @(posedge clk_i) begin
    pair_verdict_t got, want;
    if (rst_ni && verdict_ch.valid && verdict_ch.ready) begin
      got = {verdict_ch.equal, verdict_ch.mismatch_count, verdict_ch.match_quality,
             verdict_ch.length_differs};
      if (verdicts_due.size() == 0) begin
        error_count++;
        if (error_count <= MaxShown)
          $display("unexpected result word at %0t: equal=%0b count=%0d quality=%0d diff=%0b",
                   $time, got.equal, got.mismatch_count, got.match_quality,
                   got.length_differs);
      end else begin
        want = verdicts_due.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= MaxShown)
            $display({"result mismatch at %0t: expected equal=%0b count=%0d quality=%0d ",
                      "diff=%0b, got equal=%0b count=%0d quality=%0d diff=%0b"},
                     $time, want.equal, want.mismatch_count, want.match_quality,
                     want.length_differs, got.equal, got.mismatch_count,
                     got.match_quality, got.length_differs);
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb: errors");
    $finish;
  end

endmodule
